// ===== rtl/ddd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, widths and calendar tables for the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int COUNT_W  = 21;
    localparam int ORD_W    = 9;
    localparam int C100_W   = 7;
    localparam int C400_W   = 9;

    localparam int DEFAULT_MAX_YEAR = 4095;

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [C100_W-1:0] CENTURY_LAST  = C100_W'(99);
    localparam logic [C400_W-1:0] QUADCENT_LAST = C400_W'(399);

    localparam logic [COUNT_W-1:0] DAYS_COMMON = COUNT_W'(365);

    // one request: two dates
    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               date_invalid;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic res_load;
    } ddd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } ddd_status_t;

    // days in months 1 .. m-1 of a common year; months 13 and up count 31
    function automatic logic [ORD_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [ORD_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            4'd13:   r = 9'd365;
            4'd14:   r = 9'd396;
            4'd15:   r = 9'd427;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // length of a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ddd_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_stream_if
// Valid/ready channel carrying one typed payload per request.
// ----------------------------------------------------------------------------
interface ddd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/date_difference_days_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// date_difference_days_top
// Absolute number of days between two Gregorian dates, with a flag for a
// malformed month or day.
// ----------------------------------------------------------------------------
// Usage:
//   dates  : sink channel, one request holds two dates (day, month, year).
//   days   : source channel, one result per request (day_count, date_invalid).
//   A request is taken only while the block is idle. The datapath walks the
//   years 0 .. max(first_year, second_year) at one year per cycle, summing
//   365 or 366 days for each date, and then finishes the day numbers and
//   registers the result. The year walker is the only loop and sets the
//   throughput; a new request waits until the previous result is loaded.
//   Years above MAX_YEAR saturate to MAX_YEAR.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next request is accepted and worked on, and the block waits
//   only if that next result is ready before the previous one was taken.
//   Reset clears the sequencer and the result valid flag; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
module date_difference_days_top
    import ddd_pkg::*;
#(
    parameter int MAX_YEAR = DEFAULT_MAX_YEAR
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ddd_stream_if.sink       dates,
    ddd_stream_if.source     days
);

    ddd_cmd_t    cmd;
    ddd_status_t status;
    in_item_t    in_data;
    out_item_t   out_data;

    assign in_data   = dates.data;
    assign days.data = out_data;

    // sequencer
    ddd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dates.valid),
        .in_ready  (dates.ready),
        .out_valid (days.valid),
        .out_ready (days.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // year walker and arithmetic
    ddd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/ddd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_ctrl
// Sequencer: accept a request, walk the years, finish the day numbers,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module ddd_ctrl
    import ddd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ddd_cmd_t         cmd,
    input  wire ddd_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       res_free;

    // output register can take a new result
    assign res_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.finish   = 1'b0;
        cmd.res_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (res_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ddd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_datapath
// Year walker with leap counters, per-date day accumulators, ordinal
// finish and the absolute difference into the output register.
// ----------------------------------------------------------------------------
module ddd_datapath
    import ddd_pkg::*;
#(
    parameter int MAX_YEAR = DEFAULT_MAX_YEAR
)
(
    input  wire logic     clk,
    input  wire in_item_t in_data,
    input  wire ddd_cmd_t cmd,
    output ddd_status_t   status,
    output out_item_t     out_data
);

    logic [DAY_W-1:0]   d1_reg, d2_reg;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [YEAR_W-1:0]  y1_reg, y2_reg, ymax_reg;
    logic [YEAR_W-1:0]  walk_reg;
    logic [C100_W-1:0]  c100_reg;
    logic [C400_W-1:0]  c400_reg;
    logic [COUNT_W-1:0] acc1_reg, acc2_reg;
    logic               leap1_reg, leap2_reg;
    logic [COUNT_W-1:0] a1_reg, a2_reg;
    logic               bad_reg;
    out_item_t          res_reg;

    logic [YEAR_W-1:0]  y1_clamp, y2_clamp;
    logic               leap_now;
    logic [COUNT_W-1:0] year_days;
    logic [COUNT_W-1:0] a1_next, a2_next, diff;
    logic               bad1, bad2;

    // saturate years at the configured maximum
    assign y1_clamp = (32'(in_data.first_year) > MAX_YEAR) ? YEAR_W'(MAX_YEAR)
                                                           : in_data.first_year;
    assign y2_clamp = (32'(in_data.second_year) > MAX_YEAR) ? YEAR_W'(MAX_YEAR)
                                                            : in_data.second_year;

    // leap test of the walked year from its residue counters
    assign leap_now  = (c400_reg == '0) ||
                       ((walk_reg[1:0] == 2'b00) && (c100_reg != '0));
    assign year_days = DAYS_COMMON + COUNT_W'(leap_now);
    assign status.last = (walk_reg == ymax_reg);

    // day numbers: years before plus ordinal
    always_comb
    begin
        a1_next = acc1_reg + COUNT_W'(cum_days(m1_reg)) + COUNT_W'(d1_reg)
                + COUNT_W'(leap1_reg && (m1_reg > MONTH_FEB));
        a2_next = acc2_reg + COUNT_W'(cum_days(m2_reg)) + COUNT_W'(d2_reg)
                + COUNT_W'(leap2_reg && (m2_reg > MONTH_FEB));
    end

    // malformed date checks
    always_comb
    begin
        bad1 = !(m1_reg inside {[4'd1:MONTH_DEC]}) || (d1_reg == '0) ||
               (d1_reg > month_len(m1_reg, leap1_reg));
        bad2 = !(m2_reg inside {[4'd1:MONTH_DEC]}) || (d2_reg == '0) ||
               (d2_reg > month_len(m2_reg, leap2_reg));
    end

    assign diff = (a1_reg >= a2_reg) ? (a1_reg - a2_reg) : (a2_reg - a1_reg);

    always_ff @(posedge clk)
    begin
        // capture a new request
        if (cmd.load)
        begin
            d1_reg    <= in_data.first_day;
            m1_reg    <= in_data.first_month;
            y1_reg    <= y1_clamp;
            d2_reg    <= in_data.second_day;
            m2_reg    <= in_data.second_month;
            y2_reg    <= y2_clamp;
            ymax_reg  <= (y1_clamp > y2_clamp) ? y1_clamp : y2_clamp;
            walk_reg  <= '0;
            c100_reg  <= '0;
            c400_reg  <= '0;
            acc1_reg  <= '0;
            acc2_reg  <= '0;
            leap1_reg <= 1'b0;
            leap2_reg <= 1'b0;
        end
        // one year per cycle
        else if (cmd.step)
        begin
            if (walk_reg < y1_reg)
            begin
                acc1_reg <= acc1_reg + year_days;
            end
            if (walk_reg < y2_reg)
            begin
                acc2_reg <= acc2_reg + year_days;
            end
            if (walk_reg == y1_reg)
            begin
                leap1_reg <= leap_now;
            end
            if (walk_reg == y2_reg)
            begin
                leap2_reg <= leap_now;
            end
            if (!status.last)
            begin
                walk_reg <= walk_reg + 1'b1;
                c100_reg <= (c100_reg == CENTURY_LAST) ? '0 : c100_reg + 1'b1;
                c400_reg <= (c400_reg == QUADCENT_LAST) ? '0 : c400_reg + 1'b1;
            end
        end

        // finish both day numbers
        if (cmd.finish)
        begin
            a1_reg  <= a1_next;
            a2_reg  <= a2_next;
            bad_reg <= bad1 || bad2;
        end

        // result register
        if (cmd.res_load)
        begin
            res_reg.day_count    <= diff;
            res_reg.date_invalid <= bad_reg;
        end
    end

    assign out_data = res_reg;

endmodule
`default_nettype wire
